[rtl/tlmc_pkg.sv]
// Package: payload types, phase codes, lamp and segment patterns for the traffic light controller.
`timescale 1ns / 1ps

package tlmc_pkg;

    typedef struct packed {
        logic [3:0] mode_switch;
        logic       cross_clear;
        logic       ped_press;
    } t_in;

    typedef struct packed {
        logic [11:0] lamp_pins;
        logic [10:0] segment_pins;
        logic        walk_active;
        logic        mode_fault;
        logic [2:0]  phase;
    } t_out;

    typedef enum logic [6:0] {
        ST_EW_GREEN  = 7'b0000001,
        ST_EW_YELLOW = 7'b0000010,
        ST_NS_GREEN  = 7'b0000100,
        ST_NS_YELLOW = 7'b0001000,
        ST_WALK      = 7'b0010000,
        ST_FAULT     = 7'b0100000,
        ST_IDLE      = 7'b1000000
    } t_phase;

    localparam logic [2:0] PH_EW_GREEN  = 3'd0;
    localparam logic [2:0] PH_EW_YELLOW = 3'd1;
    localparam logic [2:0] PH_NS_GREEN  = 3'd2;
    localparam logic [2:0] PH_NS_YELLOW = 3'd3;
    localparam logic [2:0] PH_WALK      = 3'd4;
    localparam logic [2:0] PH_FAULT     = 3'd5;
    localparam logic [2:0] PH_IDLE      = 3'd6;

    localparam logic [3:0] MODE_URBAN       = 4'd1;
    localparam logic [3:0] MODE_RURAL       = 4'd2;
    localparam logic [3:0] MODE_URBAN_CROSS = 4'd4;
    localparam logic [3:0] MODE_RURAL_CROSS = 4'd8;

    localparam logic [2:0] CFG_GREEN_TIME      = 3'd0;
    localparam logic [2:0] CFG_YELLOW_TIME     = 3'd1;
    localparam logic [2:0] CFG_MIN_GREEN_TIME  = 3'd2;
    localparam logic [2:0] CFG_WALK_STEP_TIME  = 3'd3;
    localparam logic [2:0] CFG_FAULT_HOLD_TIME = 3'd4;

    localparam logic [15:0] RST_GREEN_TIME      = 16'd5000;
    localparam logic [15:0] RST_YELLOW_TIME     = 16'd2000;
    localparam logic [15:0] RST_MIN_GREEN_TIME  = 16'd2000;
    localparam logic [15:0] RST_WALK_STEP_TIME  = 16'd1000;
    localparam logic [15:0] RST_FAULT_HOLD_TIME = 16'd13000;

    localparam logic [11:0] LAMP_EW_GREEN  = 12'h801;
    localparam logic [11:0] LAMP_EW_YELLOW = 12'h802;
    localparam logic [11:0] LAMP_NS_GREEN  = 12'h00C;
    localparam logic [11:0] LAMP_NS_YELLOW = 12'h404;

    localparam logic [11:0] WALK_LAMPS [16] = '{
        12'h904, 12'h904, 12'h804, 12'h904, 12'h904, 12'h904, 12'h904, 12'h904,
        12'h804, 12'h804, 12'h804, 12'h804, 12'h804, 12'h804, 12'h804, 12'h804
    };

    localparam logic [10:0] WALK_SEGS [16] = '{
        11'h605, 11'h745, 11'h405, 11'h740, 11'h641, 11'h604, 11'h445, 11'h145,
        11'h404, 11'h745, 11'h000, 11'h745, 11'h000, 11'h000, 11'h000, 11'h000
    };

endpackage

[rtl/traffic_light_mode_controller_unit.sv]
// Top level: traffic light mode controller with pedestrian walk countdown.
`timescale 1ns / 1ps

// One input transfer is one millisecond tick and yields exactly one result transfer, shown in
// the output register on the following cycle. A tick is accepted in every cycle in which the
// output register is empty or its result is being taken, so the sustained rate is one tick per
// cycle; the only path is the phase register and its 16-bit timer compare. Configuration writes
// are always ready and should be made while no tick is in flight; indexes above four are
// ignored. WALK_STEPS sets the length of the pedestrian countdown (1 to 16 steps).
module traffic_light_mode_controller_unit #(
    parameter int WALK_STEPS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tlmc_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tlmc_pkg::t_out     o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import tlmc_pkg::*;

    localparam logic [4:0] STEPS = 5'(WALK_STEPS);

    logic [15:0] r_green_time, r_yellow_time, r_min_green_time;
    logic [15:0] r_walk_step_time, r_fault_hold_time;

    t_phase      r_phase, n_phase;
    t_phase      r_after_walk, n_after_walk;
    logic [15:0] r_timer, n_timer;
    logic [3:0]  r_walk_index, n_walk_index;
    logic        r_request, n_request;
    logic [3:0]  r_mode, n_mode;
    logic        r_out_valid;
    t_out        r_out_data, n_out_data;

    logic        in_xfer;
    logic        crossing;
    logic        in_drive;
    logic [15:0] t_inc;
    logic [15:0] need;
    logic        green_done;
    logic        mode_ok;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_time      <= RST_GREEN_TIME;
            r_yellow_time     <= RST_YELLOW_TIME;
            r_min_green_time  <= RST_MIN_GREEN_TIME;
            r_walk_step_time  <= RST_WALK_STEP_TIME;
            r_fault_hold_time <= RST_FAULT_HOLD_TIME;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GREEN_TIME:      r_green_time      <= i_cfg_data;
                CFG_YELLOW_TIME:     r_yellow_time     <= i_cfg_data;
                CFG_MIN_GREEN_TIME:  r_min_green_time  <= i_cfg_data;
                CFG_WALK_STEP_TIME:  r_walk_step_time  <= i_cfg_data;
                CFG_FAULT_HOLD_TIME: r_fault_hold_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign crossing = (r_mode == MODE_URBAN_CROSS) || (r_mode == MODE_RURAL_CROSS);
    assign in_drive = (r_phase == ST_EW_GREEN) || (r_phase == ST_EW_YELLOW) ||
                      (r_phase == ST_NS_GREEN) || (r_phase == ST_NS_YELLOW);
    assign t_inc    = (r_timer == 16'hFFFF) ? 16'hFFFF : r_timer + 16'd1;
    assign need     = (r_mode == MODE_RURAL_CROSS) ? r_min_green_time : r_green_time;
    assign mode_ok  = (i_in_data.mode_switch == MODE_URBAN) ||
                      (i_in_data.mode_switch == MODE_RURAL) ||
                      (i_in_data.mode_switch == MODE_URBAN_CROSS) ||
                      (i_in_data.mode_switch == MODE_RURAL_CROSS);

    always_comb begin
        n_out_data = '0;
        case (r_phase)
            ST_EW_GREEN: begin
                n_out_data.lamp_pins = LAMP_EW_GREEN;
                n_out_data.phase     = PH_EW_GREEN;
            end
            ST_EW_YELLOW: begin
                n_out_data.lamp_pins = LAMP_EW_YELLOW;
                n_out_data.phase     = PH_EW_YELLOW;
            end
            ST_NS_GREEN: begin
                n_out_data.lamp_pins = LAMP_NS_GREEN;
                n_out_data.phase     = PH_NS_GREEN;
            end
            ST_NS_YELLOW: begin
                n_out_data.lamp_pins = LAMP_NS_YELLOW;
                n_out_data.phase     = PH_NS_YELLOW;
            end
            ST_WALK: begin
                n_out_data.lamp_pins    = WALK_LAMPS[r_walk_index];
                n_out_data.segment_pins = WALK_SEGS[r_walk_index];
                n_out_data.walk_active  = 1'b1;
                n_out_data.phase        = PH_WALK;
            end
            ST_FAULT: begin
                n_out_data.mode_fault = 1'b1;
                n_out_data.phase      = PH_FAULT;
            end
            default: n_out_data.phase = PH_IDLE;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_after_walk = r_after_walk;
        n_timer      = t_inc;
        n_walk_index = r_walk_index;
        n_mode       = r_mode;
        n_request    = r_request;
        green_done   = t_inc >= at_least_one(need);

        // latch a press in the crossing modes while vehicles are driven
        if (in_drive && crossing && i_in_data.ped_press) begin
            n_request = 1'b1;
        end
        if (r_mode == MODE_RURAL) begin
            green_done = green_done && !i_in_data.cross_clear;
        end
        if (r_mode == MODE_RURAL_CROSS) begin
            green_done = green_done && (!i_in_data.cross_clear || n_request);
        end

        case (r_phase)
            ST_EW_GREEN, ST_NS_GREEN: begin
                if (green_done) begin
                    n_phase = (r_phase == ST_EW_GREEN) ? ST_EW_YELLOW : ST_NS_YELLOW;
                    n_timer = '0;
                end
            end
            ST_EW_YELLOW, ST_NS_YELLOW: begin
                if (t_inc >= at_least_one(r_yellow_time)) begin
                    n_timer = '0;
                    if (n_request && crossing) begin
                        n_request    = 1'b0;
                        n_walk_index = '0;
                        n_phase      = ST_WALK;
                        if (r_phase == ST_EW_YELLOW) begin
                            n_after_walk = ST_NS_GREEN;
                        end else if (r_mode == MODE_RURAL_CROSS) begin
                            n_after_walk = ST_EW_GREEN;
                        end else begin
                            n_after_walk = ST_IDLE;
                        end
                    end else begin
                        n_phase = (r_phase == ST_EW_YELLOW) ? ST_NS_GREEN : ST_IDLE;
                    end
                end
            end
            ST_WALK: begin
                if (t_inc >= at_least_one(r_walk_step_time)) begin
                    n_timer = '0;
                    if ({1'b0, r_walk_index} + 5'd1 >= STEPS) begin
                        n_walk_index = '0;
                        n_phase      = r_after_walk;
                    end else begin
                        n_walk_index = r_walk_index + 4'd1;
                    end
                end
            end
            ST_FAULT: begin
                if (t_inc >= at_least_one(r_fault_hold_time)) begin
                    n_phase = ST_IDLE;
                    n_timer = '0;
                end
            end
            default: begin
                n_request    = 1'b0;
                n_walk_index = '0;
                n_timer      = '0;
                if (mode_ok) begin
                    n_mode  = i_in_data.mode_switch;
                    n_phase = ST_EW_GREEN;
                end else begin
                    n_phase = ST_FAULT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ST_IDLE;
            r_after_walk <= ST_EW_GREEN;
            r_timer      <= '0;
            r_walk_index <= '0;
            r_request    <= 1'b0;
            r_mode       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase      <= n_phase;
                r_after_walk <= n_after_walk;
                r_timer      <= n_timer;
                r_walk_index <= n_walk_index;
                r_request    <= n_request;
                r_mode       <= n_mode;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

[rtl/tlmc_checker.sv]
// Checker: port-level assertions for the traffic light controller, bound to the top level.
`timescale 1ns / 1ps

module tlmc_port_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input tlmc_pkg::t_out o_out_data
);
    import tlmc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_in_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("tick transfer without a result");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");

    a_walk_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.walk_active |->
            o_out_data.phase == PH_WALK && o_out_data.lamp_pins != 12'd0 &&
            !o_out_data.mode_fault)
        else $error("walk result inconsistent");

    a_fault_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.mode_fault |->
            o_out_data.phase == PH_FAULT && o_out_data.lamp_pins == 12'd0 &&
            o_out_data.segment_pins == 11'd0)
        else $error("fault result inconsistent");

endmodule

bind traffic_light_mode_controller_unit tlmc_port_checker u_tlmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[test/tlmc_checker.sv]
// Checker: predicts every result of the traffic light controller from the ticks it accepts.
`timescale 1ns / 1ps

module tlmc_checker #(
    parameter int WALK_STEPS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  tlmc_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  tlmc_pkg::t_out i_out_data,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    output int             o_fail_cnt,
    output int             o_pending
);

    import tlmc_pkg::*;

    localparam logic [15:0] DEF_GREEN_MS     = 16'd5000;
    localparam logic [15:0] DEF_YELLOW_MS    = 16'd2000;
    localparam logic [15:0] DEF_MIN_GREEN_MS = 16'd2000;
    localparam logic [15:0] DEF_STEP_MS      = 16'd1000;
    localparam logic [15:0] DEF_FAULT_MS     = 16'd13000;

    localparam logic [11:0] LIGHT_LAMPS [4] = '{12'h801, 12'h802, 12'h00C, 12'h404};

    localparam logic [11:0] STEP_LAMPS [16] = '{
        12'h904, 12'h904, 12'h804, 12'h904, 12'h904, 12'h904, 12'h904, 12'h904,
        12'h804, 12'h804, 12'h804, 12'h804, 12'h804, 12'h804, 12'h804, 12'h804
    };

    localparam logic [10:0] STEP_SEGS [16] = '{
        11'h605, 11'h745, 11'h405, 11'h740, 11'h641, 11'h604, 11'h445, 11'h145,
        11'h404, 11'h745, 11'h000, 11'h745, 11'h000, 11'h000, 11'h000, 11'h000
    };

    logic [15:0] green_ms;
    logic [15:0] yellow_ms;
    logic [15:0] min_green_ms;
    logic [15:0] step_ms;
    logic [15:0] fault_ms;

    logic [2:0]  cur_ph;
    logic [2:0]  ret_ph;
    logic [15:0] ph_timer;
    logic [3:0]  step_idx;
    logic [3:0]  run_mode;
    logic        req_latch;

    t_out        lamp_due [$];
    int          miss_cnt = 0;

    assign o_fail_cnt = miss_cnt;

    function automatic logic [15:0] floor_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic void enter_phase(input logic [2:0] p);
        cur_ph   = p;
        ph_timer = 16'd0;
    endfunction

    function automatic t_out light_step(input t_in tick);
        t_out        r;
        logic        crossing;
        logic        done;
        logic [15:0] t;
        logic [15:0] need;
        r        = '0;
        crossing = (run_mode == MODE_URBAN_CROSS) || (run_mode == MODE_RURAL_CROSS);
        t        = (ph_timer != 16'hFFFF) ? ph_timer + 16'd1 : ph_timer;

        if (cur_ph <= PH_NS_YELLOW) begin
            r.lamp_pins = LIGHT_LAMPS[cur_ph[1:0]];
        end else if (cur_ph == PH_WALK) begin
            r.lamp_pins    = STEP_LAMPS[step_idx];
            r.segment_pins = STEP_SEGS[step_idx];
            r.walk_active  = 1'b1;
        end else if (cur_ph == PH_FAULT) begin
            r.mode_fault = 1'b1;
        end
        r.phase = cur_ph;

        if (cur_ph <= PH_NS_YELLOW && crossing && tick.ped_press) req_latch = 1'b1;

        case (cur_ph)
            PH_EW_GREEN, PH_NS_GREEN: begin
                need = (run_mode == MODE_RURAL_CROSS) ? min_green_ms : green_ms;
                done = (t >= floor_one(need));
                if (run_mode == MODE_RURAL) done = done && !tick.cross_clear;
                if (run_mode == MODE_RURAL_CROSS) done = done && (!tick.cross_clear || req_latch);
                if (done) enter_phase(cur_ph + 3'd1);
                else ph_timer = t;
            end
            PH_EW_YELLOW, PH_NS_YELLOW: begin
                if (t >= floor_one(yellow_ms)) begin
                    if (req_latch && crossing) begin
                        req_latch = 1'b0;
                        if (cur_ph == PH_EW_YELLOW) ret_ph = PH_NS_GREEN;
                        else ret_ph = (run_mode == MODE_RURAL_CROSS) ? PH_EW_GREEN : PH_IDLE;
                        step_idx = 4'd0;
                        enter_phase(PH_WALK);
                    end else begin
                        enter_phase((cur_ph == PH_EW_YELLOW) ? PH_NS_GREEN : PH_IDLE);
                    end
                end else begin
                    ph_timer = t;
                end
            end
            PH_WALK: begin
                if (t >= floor_one(step_ms)) begin
                    ph_timer = 16'd0;
                    if (int'(step_idx) + 1 >= WALK_STEPS) begin
                        step_idx = 4'd0;
                        enter_phase(ret_ph);
                    end else begin
                        step_idx = step_idx + 4'd1;
                    end
                end else begin
                    ph_timer = t;
                end
            end
            PH_FAULT: begin
                if (t >= floor_one(fault_ms)) enter_phase(PH_IDLE);
                else ph_timer = t;
            end
            default: begin
                req_latch = 1'b0;
                step_idx  = 4'd0;
                if (tick.mode_switch == MODE_URBAN || tick.mode_switch == MODE_RURAL ||
                    tick.mode_switch == MODE_URBAN_CROSS ||
                    tick.mode_switch == MODE_RURAL_CROSS) begin
                    run_mode = tick.mode_switch;
                    enter_phase(PH_EW_GREEN);
                end else begin
                    enter_phase(PH_FAULT);
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            miss_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            green_ms     = DEF_GREEN_MS;
            yellow_ms    = DEF_YELLOW_MS;
            min_green_ms = DEF_MIN_GREEN_MS;
            step_ms      = DEF_STEP_MS;
            fault_ms     = DEF_FAULT_MS;
            cur_ph       = PH_IDLE;
            ret_ph       = PH_EW_GREEN;
            ph_timer     = 16'd0;
            step_idx     = 4'd0;
            run_mode     = 4'd0;
            req_latch    = 1'b0;
            lamp_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GREEN_TIME:      green_ms     = i_cfg_data;
                    CFG_YELLOW_TIME:     yellow_ms    = i_cfg_data;
                    CFG_MIN_GREEN_TIME:  min_green_ms = i_cfg_data;
                    CFG_WALK_STEP_TIME:  step_ms      = i_cfg_data;
                    CFG_FAULT_HOLD_TIME: fault_ms     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (lamp_due.size() == 0) begin
                    $error("result transfer with no tick pending: 0x%0h", i_out_data);
                    miss_cnt++;
                end else begin
                    want = lamp_due.pop_front();
                    check_field("lamp_pins", 16'(want.lamp_pins), 16'(i_out_data.lamp_pins));
                    check_field("segment_pins", 16'(want.segment_pins),
                                16'(i_out_data.segment_pins));
                    check_field("walk_active", 16'(want.walk_active),
                                16'(i_out_data.walk_active));
                    check_field("mode_fault", 16'(want.mode_fault), 16'(i_out_data.mode_fault));
                    check_field("phase", 16'(want.phase), 16'(i_out_data.phase));
                end
            end
            if (i_in_valid && i_in_ready) lamp_due.push_back(light_step(i_in_data));
        end
        o_pending <= lamp_due.size();
    end

endmodule

[test/tb_top.sv]
// Testbench top: drives ticks, register writes and result backpressure, and reports the verdict.
`timescale 1ns / 1ps

module tb_top;

    import tlmc_pkg::*;

    localparam int WALK_STEPS  = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PHASES = 6;
    localparam int RAND_TICKS  = 180;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_cnt;
    int          pending;

    bit          tx_idle;
    bit          rx_idle;
    bit          hold_req;
    bit          hold_served;

    traffic_light_mode_controller_unit #(
        .WALK_STEPS(WALK_STEPS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    tlmc_checker #(
        .WALK_STEPS(WALK_STEPS)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [15:0] short_ms(input int hi);
        return 16'($urandom_range(hi, 1));
    endfunction

    function automatic t_in random_tick(input int press_pct, input int clear_pct);
        t_in tick;
        if ($urandom_range(99) < 88) tick.mode_switch = 4'd1 << $urandom_range(3);
        else tick.mode_switch = 4'($urandom_range(15));
        tick.cross_clear = ($urandom_range(99) < clear_pct);
        tick.ped_press   = ($urandom_range(99) < press_pct);
        return tick;
    endfunction

    task automatic send_tick(input t_in tick);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        do @(posedge clk); while (!in_ready);
    endtask

    // drop valid and hold until every result is back
    task automatic drain_lamps();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic program_timing(input logic [15:0] g, y, mg, ws, fh, input bit junk);
        logic [15:0] vals [5];
        int          j;
        vals = '{g, y, mg, ws, fh};
        for (j = 0; j < 5; j++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_GREEN_TIME + 3'(j);
            cfg_data  <= vals[j];
            do @(posedge clk); while (!cfg_ready);
        end
        if (junk) begin
            for (j = 1; j <= 3; j++) begin
                cfg_valid <= 1'b1;
                cfg_index <= CFG_FAULT_HOLD_TIME + 3'(j);
                cfg_data  <= 16'($urandom_range(65535));
                do @(posedge clk); while (!cfg_ready);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = rx_idle ? pick_gap() : 0;
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        t_in tick;
        int  k;
        int  p;
        int  hi;
        int  press_pct;
        int  clear_pct;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_req    = 1'b0;
        hold_served = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: start of an urban crossing green with a latched press
        for (k = 0; k < 100; k++) begin
            tick = random_tick(0, 50);
            tick.mode_switch = MODE_URBAN_CROSS;
            tick.ped_press   = (k == 10);
            send_tick(tick);
        end
        drain_lamps();

        program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (k = 0; k < 25; k++) begin
            case (k)
                0:       tick = '{mode_switch: 4'd0, cross_clear: 1'b1, ped_press: 1'b1};
                1:       tick = '{mode_switch: MODE_URBAN, cross_clear: 1'b0, ped_press: 1'b0};
                2:       tick = '{mode_switch: 4'hF, cross_clear: 1'b0, ped_press: 1'b1};
                3:       tick = '{mode_switch: MODE_URBAN, cross_clear: 1'b1, ped_press: 1'b0};
                4:       tick = '{mode_switch: MODE_URBAN_CROSS, cross_clear: 1'b1, ped_press: 1'b0};
                5:       tick = '{mode_switch: MODE_URBAN_CROSS, cross_clear: 1'b1, ped_press: 1'b1};
                6:       tick = '{mode_switch: MODE_URBAN_CROSS, cross_clear: 1'b0, ped_press: 1'b0};
                19, 20:  tick = '{mode_switch: MODE_URBAN_CROSS, cross_clear: 1'b1, ped_press: 1'b0};
                21, 22:  tick = '{mode_switch: MODE_RURAL_CROSS, cross_clear: 1'b1, ped_press: 1'b0};
                23:      tick = '{mode_switch: MODE_RURAL_CROSS, cross_clear: 1'b0, ped_press: 1'b0};
                24:      tick = '{mode_switch: MODE_RURAL, cross_clear: 1'b1, ped_press: 1'b1};
                default: tick = '{mode_switch: MODE_URBAN_CROSS, cross_clear: 1'b0, ped_press: 1'b1};
            endcase
            send_tick(tick);
        end
        drain_lamps();

        for (p = 0; p < RAND_PHASES; p++) begin
            hi = 4 + 4 * p;
            if (p == 1) program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
            else program_timing(short_ms(hi), short_ms(hi), short_ms(hi), short_ms(4),
                                short_ms(hi), p == 3);
            press_pct = $urandom_range(40, 5);
            clear_pct = $urandom_range(85, 20);
            tx_idle   = (p != 2);
            rx_idle   = (p != 2);
            for (k = 0; k < RAND_TICKS; k++) begin
                if (p == 4 && k == 60) hold_req = 1'b1;
                if (p == 4 && k == 120) drain_lamps();
                send_tick(random_tick(press_pct, clear_pct));
            end
            drain_lamps();
        end

        // long rural green: fault hold, then green held while the sensor stays clear
        program_timing(16'd150, 16'd3, 16'd150, 16'd150, 16'd80, 1'b0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (k = 0; k < 300; k++) begin
            tick = random_tick(30, 50);
            tick.mode_switch = (k == 0) ? 4'd0 : MODE_RURAL;
            if (k < 280) tick.cross_clear = 1'b1;
            send_tick(tick);
        end
        drain_lamps();

        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tlmc_pkg.sv
rtl/traffic_light_mode_controller_unit.sv
rtl/tlmc_checker.sv
test/tlmc_checker.sv
test/tb_top.sv
